/* src/ess_pkg.sv */
// Shared constants, types and codes for the Euclidean step sequencer.
package ess_pkg;

  localparam int MAX_STEPS  = 64;
  localparam int NUM_TRACKS = 3;

  localparam int STEP_W   = $clog2(MAX_STEPS);
  localparam int LEN_W    = $clog2(MAX_STEPS + 1);
  localparam int TRACK_W  = 2;
  localparam int PERIOD_W = 16;
  localparam int TOTAL_W  = 7;
  localparam int COUNT_W  = 7;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(1000);
  localparam logic [TOTAL_W-1:0]  TOTAL_RST  = TOTAL_W'(16);

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_STEPS = 1'b1;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_SET    = 2'd1,
    REQ_FILL   = 2'd2,
    REQ_TOGGLE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_EXEC
  } state_t;

  typedef logic [NUM_TRACKS-1:0] row_t;

  typedef struct packed {
    logic [STEP_W-1:0] rd_addr;
    logic              wr_en;
    logic [STEP_W-1:0] wr_addr;
    row_t              wr_data;
  } store_req_t;

endpackage

/* src/ess_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ess_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/ess_pattern_store.sv */
// Pattern memory, one row of track bits per step, with per-row valid bits.
module ess_pattern_store (
  input  logic                clk,
  input  logic                rst_n,
  input  ess_pkg::store_req_t req,
  output ess_pkg::row_t       rd_row
);

  logic [ess_pkg::MAX_STEPS-1:0] valid_r;
  logic                          rd_valid_r;
  ess_pkg::row_t                 ram_rdata;

  ess_ram #(
    .WIDTH(ess_pkg::NUM_TRACKS),
    .DEPTH(ess_pkg::MAX_STEPS)
  ) u_ram (
    .clk  (clk),
    .we   (req.wr_en),
    .waddr(req.wr_addr),
    .wdata(req.wr_data),
    .raddr(req.rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= valid_r[req.rd_addr];
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_row = rd_valid_r ? ram_rdata : '0;

endmodule

/* src/euclidean_step_sequencer.sv */
// Top level of the three-track Euclidean step sequencer.
//
//  port group | direction | handshake          | payload
//  in_        | input     | in_valid/in_ready  | req_type track_sel step_index step_on
//             |           |                    | pulse_count pattern_length
//  out_       | output    | out_valid/out_ready| triggers advanced step_now running
//  cfg_       | input     | cfg_we             | cfg_index cfg_data
//
// Tick, set and toggle are accepted in S_IDLE, where the pattern memory read is issued, and finish in S_EXEC.
// A fill passes through S_FILL, one read-modify-write of a pattern row per cycle, then finishes in S_EXEC.
// Reset clears control state and row valid bits; there is no clearing pass.
// A result waits in the output register; the next transfer is accepted meanwhile
// and holds in its last cycle until the output register is free.
module euclidean_step_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_req_type,
  input  logic [ess_pkg::TRACK_W-1:0]   in_track_sel,
  input  logic [ess_pkg::STEP_W-1:0]    in_step_index,
  input  logic                          in_step_on,
  input  logic [ess_pkg::COUNT_W-1:0]   in_pulse_count,
  input  logic [ess_pkg::COUNT_W-1:0]   in_pattern_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ess_pkg::NUM_TRACKS-1:0] out_triggers,
  output logic                          out_advanced,
  output logic [ess_pkg::STEP_W-1:0]    out_step_now,
  output logic                          out_running,
  input  logic                          cfg_we,
  input  logic [ess_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ess_pkg::CFG_W-1:0]     cfg_data
);

  ess_pkg::state_t state_r, state_nxt;

  ess_pkg::req_t                 req_r;
  logic [ess_pkg::TRACK_W-1:0]   track_r;
  logic [ess_pkg::STEP_W-1:0]    addr_r;
  logic                          son_r;
  logic [ess_pkg::COUNT_W-1:0]   k_r;
  logic [ess_pkg::COUNT_W-1:0]   n_r;

  logic [ess_pkg::STEP_W-1:0]    fill_idx_r, fill_idx_nxt;
  logic [ess_pkg::COUNT_W-1:0]   acc_r, acc_nxt;

  logic [ess_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [ess_pkg::PERIOD_W-1:0]  tick_r, tick_nxt;
  logic                          run_r, run_nxt;

  logic [ess_pkg::PERIOD_W-1:0]  period_r;
  logic [ess_pkg::TOTAL_W-1:0]   total_r;

  logic                          out_valid_r;
  ess_pkg::row_t                 trig_r, trig_nxt;
  logic                          adv_r, adv_nxt;

  ess_pkg::store_req_t           st_req;
  ess_pkg::row_t                 rd_row;
  ess_pkg::row_t                 new_row;

  logic [ess_pkg::LEN_W-1:0]     loop_len;
  logic                          in_fire;
  logic                          commit;
  logic                          bit_val;
  logic                          fill_on;
  logic [ess_pkg::COUNT_W:0]     acc_sum;
  logic [ess_pkg::PERIOD_W-1:0]  tick_inc;
  logic [ess_pkg::LEN_W-1:0]     step_inc;
  logic [ess_pkg::LEN_W-1:0]     fill_inc;

  ess_pattern_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (st_req),
    .rd_row(rd_row)
  );

  assign in_ready = (state_r == ess_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign commit   = (state_r == ess_pkg::S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    if (total_r == '0) begin
      loop_len = ess_pkg::LEN_W'(1);
    end else if (ess_pkg::LEN_W'(total_r) > ess_pkg::LEN_W'(ess_pkg::MAX_STEPS)) begin
      loop_len = ess_pkg::LEN_W'(ess_pkg::MAX_STEPS);
    end else begin
      loop_len = ess_pkg::LEN_W'(total_r);
    end
  end

  assign acc_sum  = {1'b0, acc_r} + {1'b0, k_r};
  assign fill_on  = (ess_pkg::COUNT_W'(fill_idx_r) < n_r) && ((k_r >= n_r) || (acc_r < k_r));
  assign bit_val  = (state_r == ess_pkg::S_FILL) ? fill_on : son_r;
  assign tick_inc = tick_r + ess_pkg::PERIOD_W'(1);
  assign step_inc = ess_pkg::LEN_W'(step_r) + ess_pkg::LEN_W'(1);
  assign fill_inc = ess_pkg::LEN_W'(fill_idx_r) + ess_pkg::LEN_W'(1);

  always_comb begin
    for (int t = 0; t < ess_pkg::NUM_TRACKS; t++) begin
      new_row[t] = (ess_pkg::TRACK_W'(t) == track_r) ? bit_val : rd_row[t];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    fill_idx_nxt    = fill_idx_r;
    acc_nxt         = acc_r;
    step_nxt        = step_r;
    tick_nxt        = tick_r;
    run_nxt         = run_r;
    trig_nxt        = '0;
    adv_nxt         = 1'b0;
    st_req.rd_addr  = (req_r == ess_pkg::REQ_SET) ? addr_r : step_r;
    st_req.wr_en    = 1'b0;
    st_req.wr_addr  = addr_r;
    st_req.wr_data  = new_row;

    case (state_r)
      ess_pkg::S_IDLE: begin
        case (ess_pkg::req_t'(in_req_type))
          ess_pkg::REQ_SET:  st_req.rd_addr = in_step_index;
          ess_pkg::REQ_FILL: st_req.rd_addr = '0;
          default:           st_req.rd_addr = step_r;
        endcase
        if (in_fire) begin
          fill_idx_nxt = '0;
          acc_nxt      = '0;
          if (ess_pkg::req_t'(in_req_type) == ess_pkg::REQ_FILL &&
              in_track_sel < ess_pkg::TRACK_W'(ess_pkg::NUM_TRACKS)) begin
            state_nxt = ess_pkg::S_FILL;
          end else begin
            state_nxt = ess_pkg::S_EXEC;
          end
        end
      end
      ess_pkg::S_FILL: begin
        st_req.wr_en   = 1'b1;
        st_req.wr_addr = fill_idx_r;
        st_req.rd_addr = ess_pkg::STEP_W'(fill_inc);
        fill_idx_nxt   = ess_pkg::STEP_W'(fill_inc);
        acc_nxt        = (acc_sum >= {1'b0, n_r}) ? ess_pkg::COUNT_W'(acc_sum - {1'b0, n_r})
                                                  : ess_pkg::COUNT_W'(acc_sum);
        if (fill_inc >= loop_len) begin
          state_nxt = ess_pkg::S_EXEC;
        end
      end
      ess_pkg::S_EXEC: begin
        if (commit) begin
          state_nxt = ess_pkg::S_IDLE;
          case (req_r)
            ess_pkg::REQ_TICK: begin
              if (run_r) begin
                if (tick_inc >= period_r) begin
                  trig_nxt = rd_row;
                  adv_nxt  = 1'b1;
                  tick_nxt = '0;
                  step_nxt = (step_inc >= loop_len) ? '0 : ess_pkg::STEP_W'(step_inc);
                end else begin
                  tick_nxt = tick_inc;
                end
              end
            end
            ess_pkg::REQ_SET: begin
              if (track_r < ess_pkg::TRACK_W'(ess_pkg::NUM_TRACKS) &&
                  ess_pkg::LEN_W'(addr_r) < loop_len) begin
                st_req.wr_en = 1'b1;
              end
            end
            ess_pkg::REQ_TOGGLE: run_nxt = !run_r;
            default: ;
          endcase
        end
      end
      default: state_nxt = ess_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ess_pkg::S_IDLE;
      step_r      <= '0;
      tick_r      <= '0;
      run_r       <= 1'b0;
      period_r    <= ess_pkg::PERIOD_RST;
      total_r     <= ess_pkg::TOTAL_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      tick_r  <= tick_nxt;
      run_r   <= run_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ess_pkg::CFG_STEP_PERIOD: period_r <= cfg_data;
          ess_pkg::CFG_TOTAL_STEPS: total_r  <= ess_pkg::TOTAL_W'(cfg_data);
          default: ;
        endcase
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fill_idx_r <= fill_idx_nxt;
    acc_r      <= acc_nxt;
    if (in_fire) begin
      req_r   <= ess_pkg::req_t'(in_req_type);
      track_r <= in_track_sel;
      addr_r  <= in_step_index;
      son_r   <= in_step_on;
      k_r     <= in_pulse_count;
      n_r     <= in_pattern_length;
    end
    if (commit) begin
      trig_r <= trig_nxt;
      adv_r  <= adv_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_triggers = trig_r;
  assign out_advanced = adv_r;
  assign out_step_now = step_r;
  assign out_running  = run_r;

  a_fill_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ess_pkg::S_FILL) |-> (ess_pkg::LEN_W'(fill_idx_r) < loop_len))
    else $error("fill index beyond loop length");

  a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_req.wr_en |-> (state_r == ess_pkg::S_FILL || state_r == ess_pkg::S_EXEC))
    else $error("pattern write outside fill or execute");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_valid && state_r == ess_pkg::S_IDLE))
    else $error("committed result not presented");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ess_pkg::S_IDLE))
    else $error("accepted transfer not taken up");

  a_trig_needs_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_triggers != '0) |-> out_advanced)
    else $error("triggers without step advance");

endmodule

/* verif/tb_euclidean_step_sequencer.sv */
// Self-checking testbench for the Euclidean step sequencer: directed rows, then random phases.
module tb_euclidean_step_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASE_ITEMS = 125;
  localparam int HOLD_CYCLES = 300;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    ess_pkg::req_t                       kind;
    logic [ess_pkg::TRACK_W-1:0]         track;
    logic [ess_pkg::STEP_W-1:0]          step_idx;
    logic                                step_on;
    logic [ess_pkg::COUNT_W-1:0]         pulses;
    logic [ess_pkg::COUNT_W-1:0]         length;
  } seq_request_t;

  typedef struct packed {
    logic [ess_pkg::NUM_TRACKS-1:0] trig;
    logic                           adv;
    logic [ess_pkg::STEP_W-1:0]     step;
    logic                           run;
  } step_result_t;

  typedef struct packed {
    logic                          is_write;
    logic [ess_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [ess_pkg::CFG_W-1:0]     reg_val;
    seq_request_t                  req;
    logic                          typed;
    step_result_t                  want;
  } directed_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [1:0]                     in_req_type = '0;
  logic [ess_pkg::TRACK_W-1:0]    in_track_sel = '0;
  logic [ess_pkg::STEP_W-1:0]     in_step_index = '0;
  logic                           in_step_on = 1'b0;
  logic [ess_pkg::COUNT_W-1:0]    in_pulse_count = '0;
  logic [ess_pkg::COUNT_W-1:0]    in_pattern_length = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [ess_pkg::NUM_TRACKS-1:0] out_triggers;
  logic                           out_advanced;
  logic [ess_pkg::STEP_W-1:0]     out_step_now;
  logic                           out_running;
  logic                           cfg_we = 1'b0;
  logic [ess_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ess_pkg::CFG_W-1:0]      cfg_data = '0;

  logic [ess_pkg::MAX_STEPS-1:0] pat_bits [ess_pkg::NUM_TRACKS] = '{default: '0};
  logic [ess_pkg::STEP_W-1:0]    cur_step = '0;
  logic [ess_pkg::PERIOD_W-1:0]  tick_acc = '0;
  logic                          run_on = 1'b0;
  logic [ess_pkg::PERIOD_W-1:0]  period_reg = ess_pkg::PERIOD_RST;
  logic [ess_pkg::TOTAL_W-1:0]   total_reg = ess_pkg::TOTAL_RST;

  step_result_t  pending_results[$];
  directed_row_t directed_rows[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            stall_orders = 0;
  int            stalls_done = 0;
  int            hold_left = 0;
  bit            steady = 1'b0;

  int unsigned phase_period [8] = '{1, 2, 0, 3, 65535, 1, 4, 2};
  int unsigned phase_total  [8] = '{16, 64, 1, 127, 0, 5, 40, 64};

  euclidean_step_sequencer dut (.*);

  always #5 clk = ~clk;

  function automatic int loop_length();
    if (total_reg == 0) return 1;
    if (total_reg > ess_pkg::MAX_STEPS) return ess_pkg::MAX_STEPS;
    return int'(total_reg);
  endfunction

  task automatic predict_result(input seq_request_t r, output step_result_t res);
    int len;
    int i;
    len = loop_length();
    res = '0;
    case (r.kind)
      ess_pkg::REQ_TICK: begin
        if (run_on) begin
          tick_acc = tick_acc + 1'b1;
          if (tick_acc >= period_reg) begin
            for (i = 0; i < ess_pkg::NUM_TRACKS; i++) res.trig[i] = pat_bits[i][cur_step];
            cur_step = (int'(cur_step) + 1 >= len) ? '0 : cur_step + 1'b1;
            tick_acc = '0;
            res.adv = 1'b1;
          end
        end
      end
      ess_pkg::REQ_SET: begin
        if (r.track < ess_pkg::NUM_TRACKS && r.step_idx < len)
          pat_bits[r.track][r.step_idx] = r.step_on;
      end
      ess_pkg::REQ_FILL: begin
        if (r.track < ess_pkg::NUM_TRACKS) begin
          for (i = 0; i < len; i++) begin
            if (i < r.length) pat_bits[r.track][i] = ((i * r.pulses) % r.length) < r.pulses;
            else pat_bits[r.track][i] = 1'b0;
          end
        end
      end
      default: begin
        run_on = !run_on;
      end
    endcase
    res.step = cur_step;
    res.run = run_on;
  endtask

  function automatic seq_request_t random_request();
    seq_request_t r;
    int len;
    int roll;
    int toggle_pct;
    len = loop_length();
    r.track = ess_pkg::TRACK_W'($urandom_range(0, 3));
    r.step_idx = ess_pkg::STEP_W'($urandom_range(0, 63));
    r.step_on = 1'($urandom_range(0, 1));
    r.pulses = ess_pkg::COUNT_W'($urandom_range(0, 127));
    r.length = ess_pkg::COUNT_W'($urandom_range(0, 127));
    toggle_pct = run_on ? 4 : 40;
    roll = $urandom_range(0, 99);
    if (roll < toggle_pct) begin
      r.kind = ess_pkg::REQ_TOGGLE;
    end else if (roll < toggle_pct + 12) begin
      r.kind = ess_pkg::REQ_SET;
      if ($urandom_range(0, 4) != 0) r.step_idx = ess_pkg::STEP_W'($urandom_range(0, len - 1));
    end else if (roll < toggle_pct + 18) begin
      r.kind = ess_pkg::REQ_FILL;
      if ($urandom_range(0, 3) != 0) begin
        r.pulses = ess_pkg::COUNT_W'($urandom_range(0, len));
        r.length = ess_pkg::COUNT_W'($urandom_range(0, len));
      end
    end else begin
      r.kind = ess_pkg::REQ_TICK;
    end
    return r;
  endfunction

  task automatic send_request(input seq_request_t r, input logic typed, input step_result_t want);
    int gap;
    step_result_t predicted;
    gap = 0;
    while (!steady && gap < 12 && $urandom_range(0, 99) < 24) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= r.kind;
    in_track_sel      <= r.track;
    in_step_index     <= r.step_idx;
    in_step_on        <= r.step_on;
    in_pulse_count    <= r.pulses;
    in_pattern_length <= r.length;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_result(r, predicted);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
  endtask

  // Hold the input side and drain all results before touching a register.
  task automatic write_register(input logic [ess_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ess_pkg::CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ess_pkg::CFG_STEP_PERIOD) period_reg = val;
    else total_reg = val[ess_pkg::TOTAL_W-1:0];
  endtask

  task automatic add_req(input ess_pkg::req_t kind, input int trk, input int sidx, input int on,
                         input int k, input int n);
    directed_row_t row;
    row = '0;
    row.req.kind = kind;
    row.req.track = ess_pkg::TRACK_W'(trk);
    row.req.step_idx = ess_pkg::STEP_W'(sidx);
    row.req.step_on = 1'(on);
    row.req.pulses = ess_pkg::COUNT_W'(k);
    row.req.length = ess_pkg::COUNT_W'(n);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic add_write(input logic [ess_pkg::CFG_IDX_W-1:0] idx, input int val);
    directed_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.reg_val = ess_pkg::CFG_W'(val);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic typed_result(input int trig, input int adv, input int step, input int run);
    directed_row_t row;
    row = directed_rows.pop_back();
    row.typed = 1'b1;
    row.want.trig = ess_pkg::NUM_TRACKS'(trig);
    row.want.adv = 1'(adv);
    row.want.step = ess_pkg::STEP_W'(step);
    row.want.run = 1'(run);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (stalls_done != stall_orders) begin
      stalls_done = stalls_done + 1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 24);
    end
  end

  always @(posedge clk) begin : check_transfer
    step_result_t got;
    step_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_triggers, out_advanced, out_step_now, out_running};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected transfer: trig=%b adv=%b step=%0d run=%b",
                   got.trig, got.adv, got.step, got.run);
      end else begin
        want = pending_results.pop_front();
        if (got.trig !== want.trig || got.adv !== want.adv ||
            got.step !== want.step || got.run !== want.run) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display({"mismatch: expected trig=%b adv=%b step=%0d run=%b, ",
                      "got trig=%b adv=%b step=%0d run=%b"},
                     want.trig, want.adv, want.step, want.run,
                     got.trig, got.adv, got.step, got.run);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    directed_row_t row;
    int idx;
    int p;
    logic [ess_pkg::CFG_W-1:0] per;
    logic [ess_pkg::CFG_W-1:0] tot;

    add_req(ess_pkg::REQ_TICK, 0, 0, 0, 0, 0);        typed_result(0, 0, 0, 0);
    add_req(ess_pkg::REQ_TOGGLE, 0, 0, 0, 0, 0);      typed_result(0, 0, 0, 1);
    add_req(ess_pkg::REQ_TICK, 0, 0, 0, 0, 0);        typed_result(0, 0, 0, 1);
    add_req(ess_pkg::REQ_TOGGLE, 0, 0, 0, 0, 0);      typed_result(0, 0, 0, 0);
    add_write(ess_pkg::CFG_STEP_PERIOD, 1);
    add_req(ess_pkg::REQ_FILL, 0, 0, 0, 4, 16);
    add_req(ess_pkg::REQ_FILL, 1, 0, 0, 16, 16);
    add_req(ess_pkg::REQ_FILL, 2, 0, 0, 0, 16);       typed_result(0, 0, 0, 0);
    add_req(ess_pkg::REQ_FILL, 2, 0, 0, 3, 0);        typed_result(0, 0, 0, 0);
    add_req(ess_pkg::REQ_FILL, 3, 0, 0, 5, 8);        typed_result(0, 0, 0, 0);
    add_req(ess_pkg::REQ_FILL, 2, 63, 1, 127, 127);
    add_req(ess_pkg::REQ_SET, 2, 1, 0, 0, 0);
    add_req(ess_pkg::REQ_SET, 0, 15, 1, 0, 0);
    add_req(ess_pkg::REQ_SET, 1, 16, 0, 0, 0);        typed_result(0, 0, 0, 0);
    add_req(ess_pkg::REQ_SET, 3, 0, 1, 127, 127);     typed_result(0, 0, 0, 0);
    add_req(ess_pkg::REQ_TOGGLE, 0, 0, 0, 0, 0);      typed_result(0, 0, 0, 1);
    add_req(ess_pkg::REQ_TICK, 0, 0, 0, 0, 0);        typed_result(7, 1, 1, 1);
    add_req(ess_pkg::REQ_TICK, 0, 0, 0, 0, 0);
    add_req(ess_pkg::REQ_TICK, 0, 0, 0, 0, 0);
    add_write(ess_pkg::CFG_TOTAL_STEPS, 0);
    add_req(ess_pkg::REQ_TICK, 0, 0, 0, 0, 0);
    add_req(ess_pkg::REQ_TICK, 0, 0, 0, 0, 0);
    add_req(ess_pkg::REQ_FILL, 0, 0, 0, 1, 1);
    add_write(ess_pkg::CFG_TOTAL_STEPS, 127);
    add_write(ess_pkg::CFG_STEP_PERIOD, 0);
    add_req(ess_pkg::REQ_SET, 0, 63, 1, 0, 0);
    add_req(ess_pkg::REQ_FILL, 1, 0, 0, 64, 64);
    add_req(ess_pkg::REQ_TICK, 0, 0, 0, 0, 0);
    add_req(ess_pkg::REQ_TICK, 0, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (idx = 0; idx < directed_rows.size(); idx++) begin
      row = directed_rows[idx];
      if (row.is_write) write_register(row.reg_idx, row.reg_val);
      else send_request(row.req, row.typed, row.want);
    end

    for (p = 0; p < 10; p++) begin
      if (p < 8) begin
        per = ess_pkg::CFG_W'(phase_period[p]);
        tot = ess_pkg::CFG_W'(phase_total[p]);
      end else begin
        per = ess_pkg::CFG_W'($urandom_range(0, 5));
        tot = ess_pkg::CFG_W'($urandom_range(0, 127));
      end
      write_register(ess_pkg::CFG_STEP_PERIOD, per);
      write_register(ess_pkg::CFG_TOTAL_STEPS, tot);
      steady = (p == 3);
      if (p == 5) stall_orders++;
      repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
